@@ rtl/gita_pkg.sv @@
// Shared types, constants and helpers for the greedy IoU track associator.
package gita_pkg;

	localparam int MAX_TRACKS_DEF = 8;
	localparam int MAX_BOXES_DEF  = 8;

	localparam logic [16:0] MIN_OVERLAP_RST = 17'd32768;
	localparam logic [16:0] MAX_DIST_RST    = 17'd8192;
	localparam logic [31:0] TIMEOUT_RST     = 32'd1000000;
	localparam logic [34:0] Q16_ONE         = 35'd65536;

	localparam logic [1:0] REG_MIN_OVERLAP = 2'd0;
	localparam logic [1:0] REG_MAX_DIST    = 2'd1;
	localparam logic [1:0] REG_TIMEOUT     = 2'd2;

	typedef struct packed {
		logic [15:0] cx;
		logic [15:0] cy;
		logic [15:0] w;
		logic [15:0] h;
	} box_t;

	typedef struct packed {
		logic [31:0] key;
		box_t        box;
		logic [47:0] seen;
	} track_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXP_RD,
		ST_EXP_CHK,
		ST_SCAN_INIT,
		ST_PAIR_RD,
		ST_PAIR_GEO,
		ST_PAIR_EVAL,
		ST_SCAN_END,
		ST_EM_RD,
		ST_EM_WR
	} state_t;

	// One 18-bit digit of a 35-bit value, zero extended to 36 bits.
	function automatic logic [17:0] digit18(input logic [34:0] v, input logic sel);
		logic [35:0] ext;
		ext = {1'b0, v};
		return sel ? ext[35:18] : ext[17:0];
	endfunction

endpackage

@@ rtl/greedy_iou_track_associator.sv @@
// Greedy IoU track associator: box store, track memory and matching sequencer.
// Flow: an item without frame_end is accepted whenever the block is idle. A frame_end
// item runs expiry over every track slot, then scans the box-track pairs, an IoU pass
// and then a distance pass, then a read and a write per result, each one waiting until
// the last result is taken. The shared 18x18 multiplier and one track read port set the pace.
// Reset: asynchronous, active low; clears the track valid bits, box count, key counter
// and registers to their defaults. Stored boxes and tracks need no clearing pass.
module greedy_iou_track_associator #(
	parameter int MAX_TRACKS = gita_pkg::MAX_TRACKS_DEF,
	parameter int MAX_BOXES  = gita_pkg::MAX_BOXES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] centre_x,
	input  logic [15:0] centre_y,
	input  logic [15:0] box_width,
	input  logic [15:0] box_height,
	input  logic [47:0] frame_time,
	input  logic        has_box,
	input  logic        frame_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] assigned_key,
	output logic        is_new,
	output logic        table_full,
	output logic        last_result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int TW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
	localparam int BW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int CW = $clog2(MAX_BOXES + 1);
	localparam logic [TW-1:0] T_LAST = TW'(MAX_TRACKS - 1);

	// Configuration registers. Writes are only expected while the block is idle.
	logic [16:0] min_overlap_q, max_dist_q;
	logic [31:0] timeout_q;

	// Control state.
	gita_pkg::state_t state_q, state_d;
	logic [MAX_TRACKS-1:0] trk_valid_q, trk_matched_q;
	logic [MAX_BOXES-1:0]  box_matched_q;
	logic [TW-1:0]         box_track_q [MAX_BOXES];
	logic [CW-1:0]         box_count_q;
	logic [31:0]           next_key_q;
	logic [TW-1:0]         t_q, bt_q;
	logic [BW-1:0]         r_q, br_q;
	logic                  pass2_q, found_q;
	logic [3:0]            k_q;
	logic                  out_valid_q;

	// Datapath registers.
	logic [47:0] now_q;
	logic [16:0] ix_q, iy_q, awa_q, aha_q, awb_q, ahb_q;
	logic [15:0] dx_q, dy_q;
	logic [33:0] inter_q, area_a_q, area_b_q;
	logic [34:0] num_q, den_q, bn_q, bd_q, best_q;
	logic signed [73:0] acc_q;
	logic [31:0] key_q;
	logic        new_q, full_q, last_q;

	// Memories: frame box store and track table, both with registered reads.
	gita_pkg::box_t   box_mem [MAX_BOXES];
	gita_pkg::track_t trk_mem [MAX_TRACKS];
	gita_pkg::box_t   box_rd_q;
	gita_pkg::track_t trk_rd_q;
	logic [TW-1:0]    trk_raddr;
	logic             box_we, trk_we;
	logic [TW-1:0]    trk_waddr;
	gita_pkg::track_t trk_wdata;

	logic in_acc, out_acc;
	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid_q && !out_stall;

	// Pair bookkeeping for the scans.
	logic r_last, pair_last, pair_ok;
	assign r_last    = (CW'(r_q) + CW'(1)) == box_count_q;
	assign pair_last = r_last && (t_q == T_LAST);
	assign pair_ok   = !box_matched_q[r_q] && trk_valid_q[t_q] && !trk_matched_q[t_q];

	logic eval_done;
	assign eval_done = pass2_q ? (k_q == 4'd2) : (k_q == 4'd12);

	// Lowest free track slot.
	logic          free_found;
	logic [TW-1:0] free_idx;
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = MAX_TRACKS - 1; i >= 0; i--) begin
			if (!trk_valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = TW'(i);
			end
		end
	end

	// Box geometry in doubled units, so half sizes stay exact.
	logic signed [18:0] ax0, ax1, ay0, ay1, bx0, bx1, by0, by1;
	logic signed [18:0] lox, hix, loy, hiy, spx, spy;
	logic signed [16:0] cdx, cdy;
	always_comb begin
		ax0 = $signed({2'b00, box_rd_q.cx, 1'b0}) - $signed({3'b000, box_rd_q.w});
		ax1 = $signed({2'b00, box_rd_q.cx, 1'b0}) + $signed({3'b000, box_rd_q.w});
		ay0 = $signed({2'b00, box_rd_q.cy, 1'b0}) - $signed({3'b000, box_rd_q.h});
		ay1 = $signed({2'b00, box_rd_q.cy, 1'b0}) + $signed({3'b000, box_rd_q.h});
		bx0 = $signed({2'b00, trk_rd_q.box.cx, 1'b0}) - $signed({3'b000, trk_rd_q.box.w});
		bx1 = $signed({2'b00, trk_rd_q.box.cx, 1'b0}) + $signed({3'b000, trk_rd_q.box.w});
		by0 = $signed({2'b00, trk_rd_q.box.cy, 1'b0}) - $signed({3'b000, trk_rd_q.box.h});
		by1 = $signed({2'b00, trk_rd_q.box.cy, 1'b0}) + $signed({3'b000, trk_rd_q.box.h});
		lox = (ax0 > bx0) ? ax0 : bx0;
		hix = (ax1 < bx1) ? ax1 : bx1;
		loy = (ay0 > by0) ? ay0 : by0;
		hiy = (ay1 < by1) ? ay1 : by1;
		spx = hix - lox;
		spy = hiy - loy;
		cdx = $signed({1'b0, box_rd_q.cx}) - $signed({1'b0, trk_rd_q.box.cx});
		cdy = $signed({1'b0, box_rd_q.cy}) - $signed({1'b0, trk_rd_q.box.cy});
	end

	// The shared 18x18 multiplier. The fraction compare runs as eight partial
	// products accumulated into acc_q: num*bd minus bn*den.
	logic [17:0] mul_a, mul_b;
	logic [35:0] pp;
	logic [1:0]  k_lo;
	assign k_lo = k_q[1:0];
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == gita_pkg::ST_SCAN_INIT) begin
			mul_a = {1'b0, max_dist_q};
			mul_b = {1'b0, max_dist_q};
		end else if (state_q == gita_pkg::ST_PAIR_EVAL) begin
			if (pass2_q) begin
				mul_a = {2'b00, (k_q == 4'd0) ? dx_q : dy_q};
				mul_b = {2'b00, (k_q == 4'd0) ? dx_q : dy_q};
			end else begin
				case (k_q)
					4'd0: begin
						mul_a = {1'b0, ix_q};
						mul_b = {1'b0, iy_q};
					end
					4'd1: begin
						mul_a = {1'b0, awa_q};
						mul_b = {1'b0, aha_q};
					end
					4'd2: begin
						mul_a = {1'b0, awb_q};
						mul_b = {1'b0, ahb_q};
					end
					4'd4, 4'd5, 4'd6, 4'd7: begin
						mul_a = gita_pkg::digit18(num_q, k_lo[1]);
						mul_b = gita_pkg::digit18(bd_q, k_lo[0]);
					end
					4'd8, 4'd9, 4'd10, 4'd11: begin
						mul_a = gita_pkg::digit18(bn_q, k_lo[1]);
						mul_b = gita_pkg::digit18(den_q, k_lo[0]);
					end
					default: begin
						mul_a = '0;
						mul_b = '0;
					end
				endcase
			end
		end
	end
	assign pp = mul_a * mul_b;

	logic signed [73:0] term;
	always_comb begin
		case ({1'b0, k_lo[1]} + {1'b0, k_lo[0]})
			2'd0:    term = $signed(74'(pp));
			2'd1:    term = $signed(74'(pp) << 18);
			default: term = $signed(74'(pp) << 36);
		endcase
	end

	logic [34:0] uni, dsum;
	logic        iou_better, dist_better;
	assign uni  = {1'b0, area_a_q} + {1'b0, area_b_q} - {1'b0, inter_q};
	assign dsum = {1'b0, inter_q} + {1'b0, area_a_q};
	assign iou_better  = found_q ? (acc_q > 0) : !acc_q[73];
	assign dist_better = found_q ? (dsum < best_q) : (dsum <= best_q);

	logic expire;
	assign expire = trk_valid_q[t_q] && (now_q > trk_rd_q.seen)
		&& ((now_q - trk_rd_q.seen) > {16'd0, timeout_q});

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			gita_pkg::ST_IDLE:
				if (in_acc && frame_end) begin
					state_d = gita_pkg::ST_EXP_RD;
				end
			gita_pkg::ST_EXP_RD:
				state_d = gita_pkg::ST_EXP_CHK;
			gita_pkg::ST_EXP_CHK:
				if (t_q != T_LAST) begin
					state_d = gita_pkg::ST_EXP_RD;
				end else if (box_count_q == '0) begin
					state_d = gita_pkg::ST_IDLE;
				end else begin
					state_d = gita_pkg::ST_SCAN_INIT;
				end
			gita_pkg::ST_SCAN_INIT:
				state_d = gita_pkg::ST_PAIR_RD;
			gita_pkg::ST_PAIR_RD:
				if (pair_ok) begin
					state_d = gita_pkg::ST_PAIR_GEO;
				end else if (pair_last) begin
					state_d = gita_pkg::ST_SCAN_END;
				end
			gita_pkg::ST_PAIR_GEO:
				state_d = gita_pkg::ST_PAIR_EVAL;
			gita_pkg::ST_PAIR_EVAL:
				if (eval_done) begin
					state_d = pair_last ? gita_pkg::ST_SCAN_END : gita_pkg::ST_PAIR_RD;
				end
			gita_pkg::ST_SCAN_END:
				if (found_q || !pass2_q) begin
					state_d = gita_pkg::ST_SCAN_INIT;
				end else begin
					state_d = gita_pkg::ST_EM_RD;
				end
			gita_pkg::ST_EM_RD:
				if (!out_valid_q) begin
					state_d = gita_pkg::ST_EM_WR;
				end
			gita_pkg::ST_EM_WR:
				state_d = r_last ? gita_pkg::ST_IDLE : gita_pkg::ST_EM_RD;
			default:
				state_d = gita_pkg::ST_IDLE;
		endcase
	end

	// Outputs and memory strobes.
	always_comb begin
		in_stall  = (state_q != gita_pkg::ST_IDLE);
		cfg_ready = 1'b1;
		box_we    = in_acc && has_box && (box_count_q < CW'(MAX_BOXES));
		trk_raddr = (state_q == gita_pkg::ST_EM_RD) ? box_track_q[r_q] : t_q;
		trk_we    = 1'b0;
		trk_waddr = free_idx;
		trk_wdata = '{key: next_key_q, box: box_rd_q, seen: now_q};
		if (state_q == gita_pkg::ST_EM_WR) begin
			if (box_matched_q[r_q]) begin
				trk_we    = 1'b1;
				trk_waddr = box_track_q[r_q];
				trk_wdata = '{key: trk_rd_q.key, box: box_rd_q, seen: now_q};
			end else begin
				trk_we = free_found;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign assigned_key = key_q;
	assign is_new       = new_q;
	assign table_full   = full_q;
	assign last_result  = last_q;

	// Memories.
	always_ff @(posedge clk) begin
		if (box_we) begin
			box_mem[box_count_q[BW-1:0]] <= '{cx: centre_x, cy: centre_y,
				w: box_width, h: box_height};
		end
		if (trk_we) begin
			trk_mem[trk_waddr] <= trk_wdata;
		end
		box_rd_q <= box_mem[r_q];
		trk_rd_q <= trk_mem[trk_raddr];
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= gita_pkg::ST_IDLE;
			min_overlap_q <= gita_pkg::MIN_OVERLAP_RST;
			max_dist_q    <= gita_pkg::MAX_DIST_RST;
			timeout_q     <= gita_pkg::TIMEOUT_RST;
			trk_valid_q   <= '0;
			trk_matched_q <= '0;
			box_matched_q <= '0;
			box_count_q   <= '0;
			next_key_q    <= 32'd1;
			t_q           <= '0;
			r_q           <= '0;
			bt_q          <= '0;
			br_q          <= '0;
			pass2_q       <= 1'b0;
			found_q       <= 1'b0;
			k_q           <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					gita_pkg::REG_MIN_OVERLAP: min_overlap_q <= cfg_data[16:0];
					gita_pkg::REG_MAX_DIST:    max_dist_q    <= cfg_data[16:0];
					gita_pkg::REG_TIMEOUT:     timeout_q     <= cfg_data;
					default:                   ;
				endcase
			end
			if (out_acc) begin
				out_valid_q <= 1'b0;
			end
			if (box_we) begin
				box_count_q <= box_count_q + CW'(1);
			end
			case (state_q)
				gita_pkg::ST_IDLE: begin
					t_q           <= '0;
					pass2_q       <= 1'b0;
					trk_matched_q <= '0;
					box_matched_q <= '0;
				end
				gita_pkg::ST_EXP_CHK: begin
					if (expire) begin
						trk_valid_q[t_q] <= 1'b0;
					end
					t_q <= (t_q == T_LAST) ? '0 : t_q + TW'(1);
					if (t_q == T_LAST && box_count_q == '0) begin
						box_count_q <= '0;
					end
				end
				gita_pkg::ST_SCAN_INIT: begin
					t_q     <= '0;
					r_q     <= '0;
					found_q <= 1'b0;
					k_q     <= '0;
				end
				gita_pkg::ST_PAIR_RD:
					if (!pair_ok) begin
						if (t_q == T_LAST) begin
							t_q <= '0;
							r_q <= r_q + BW'(1);
						end else begin
							t_q <= t_q + TW'(1);
						end
					end
				gita_pkg::ST_PAIR_EVAL: begin
					if (eval_done) begin
						k_q <= '0;
						if (pass2_q ? dist_better : iou_better) begin
							found_q <= 1'b1;
							br_q    <= r_q;
							bt_q    <= t_q;
						end
						if (t_q == T_LAST) begin
							t_q <= '0;
							r_q <= r_q + BW'(1);
						end else begin
							t_q <= t_q + TW'(1);
						end
					end else begin
						k_q <= k_q + 4'd1;
					end
				end
				gita_pkg::ST_SCAN_END: begin
					r_q <= '0;
					if (found_q) begin
						box_matched_q[br_q] <= 1'b1;
						trk_matched_q[bt_q] <= 1'b1;
					end else begin
						pass2_q <= 1'b1;
					end
				end
				gita_pkg::ST_EM_WR: begin
					out_valid_q <= 1'b1;
					r_q         <= r_q + BW'(1);
					if (!box_matched_q[r_q] && free_found) begin
						trk_valid_q[free_idx] <= 1'b1;
						next_key_q <= (next_key_q == '1) ? 32'd1 : next_key_q + 32'd1;
					end
					if (r_last) begin
						box_count_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers, no reset needed.
	always_ff @(posedge clk) begin
		if (in_acc && frame_end) begin
			now_q <= frame_time;
		end
		case (state_q)
			gita_pkg::ST_SCAN_INIT: begin
				bn_q   <= {18'd0, min_overlap_q};
				bd_q   <= gita_pkg::Q16_ONE;
				best_q <= pp[34:0];
			end
			gita_pkg::ST_SCAN_END:
				if (found_q) begin
					box_track_q[br_q] <= bt_q;
				end
			gita_pkg::ST_PAIR_GEO: begin
				ix_q  <= spx[18] ? '0 : spx[16:0];
				iy_q  <= spy[18] ? '0 : spy[16:0];
				awa_q <= {box_rd_q.w, 1'b0};
				aha_q <= {box_rd_q.h, 1'b0};
				awb_q <= {trk_rd_q.box.w, 1'b0};
				ahb_q <= {trk_rd_q.box.h, 1'b0};
				dx_q  <= cdx[16] ? 16'(-cdx) : cdx[15:0];
				dy_q  <= cdy[16] ? 16'(-cdy) : cdy[15:0];
			end
			gita_pkg::ST_PAIR_EVAL:
				if (pass2_q) begin
					case (k_q)
						4'd0: inter_q  <= pp[33:0];
						4'd1: area_a_q <= pp[33:0];
						default:
							if (dist_better) begin
								best_q <= dsum;
							end
					endcase
				end else begin
					case (k_q)
						4'd0: inter_q  <= pp[33:0];
						4'd1: area_a_q <= pp[33:0];
						4'd2: area_b_q <= pp[33:0];
						4'd3: begin
							acc_q <= '0;
							if (uni == '0) begin
								num_q <= '0;
								den_q <= 35'd1;
							end else begin
								num_q <= {1'b0, inter_q};
								den_q <= uni;
							end
						end
						4'd4, 4'd5, 4'd6, 4'd7:  acc_q <= acc_q + term;
						4'd8, 4'd9, 4'd10, 4'd11: acc_q <= acc_q - term;
						default:
							if (iou_better) begin
								bn_q <= num_q;
								bd_q <= den_q;
							end
					endcase
				end
			gita_pkg::ST_EM_WR: begin
				last_q <= r_last;
				if (box_matched_q[r_q]) begin
					key_q  <= trk_rd_q.key;
					new_q  <= 1'b0;
					full_q <= 1'b0;
				end else if (free_found) begin
					key_q  <= next_key_q;
					new_q  <= 1'b1;
					full_q <= 1'b0;
				end else begin
					key_q  <= '0;
					new_q  <= 1'b0;
					full_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	// A result only appears from the emit step.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == gita_pkg::ST_EM_WR))
		else $error("result raised outside emit");

	// The box store never holds more than its depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		box_count_q <= CW'(MAX_BOXES))
		else $error("box count overflow");

	// Key zero is reserved for a full table.
	assert property (@(posedge clk) disable iff (!arst_n)
		next_key_q != 32'd0)
		else $error("next key is zero");

	// A new track is never reported together with a full table.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(new_q && full_q))
		else $error("new and full both set");

endmodule

@@ dv/greedy_iou_track_associator_test.sv @@
// Self-checking testbench for the greedy IoU track associator.
`timescale 1ns / 1ps

module greedy_iou_track_associator_test;

	// The index space has one slot above the three registers; a write there must do nothing.
	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam int SLOTS = 8;
	localparam int STORE = 8;
	localparam int RANDOM_ITEMS = 400;
	localparam int SETTLE = 64;
	localparam int STUCK_LIMIT = 100000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [15:0] centre_x;
	logic [15:0] centre_y;
	logic [15:0] box_width;
	logic [15:0] box_height;
	logic [47:0] frame_time;
	logic        has_box;
	logic        frame_end;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] assigned_key;
	logic        is_new;
	logic        table_full;
	logic        last_result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	greedy_iou_track_associator dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.centre_x(centre_x), .centre_y(centre_y),
		.box_width(box_width), .box_height(box_height),
		.frame_time(frame_time), .has_box(has_box), .frame_end(frame_end),
		.out_valid(out_valid), .out_stall(out_stall),
		.assigned_key(assigned_key), .is_new(is_new),
		.table_full(table_full), .last_result(last_result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// One request on the input channel, plus an optional hand-typed expectation for the
	// directed rows whose single result is obvious.
	typedef struct {
		gita_pkg::box_t box;
		logic [47:0]    stamp;
		bit             carries_box;
		bit             closes_frame;
		bit             typed;
		logic [31:0]    key;
		bit             fresh;
		bit             full;
		bit             last;
	} request_t;

	typedef struct {
		logic [31:0] key;
		bit          fresh;
		bit          full;
		bit          last;
	} assignment_t;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shadow of the tracker: registers, track table, box store and key counter.
	logic [16:0]    overlap_floor;
	logic [16:0]    centre_radius;
	logic [31:0]    stale_limit;
	bit             slot_live [SLOTS];
	logic [31:0]    slot_key  [SLOTS];
	gita_pkg::box_t slot_box  [SLOTS];
	logic [47:0]    slot_seen [SLOTS];
	gita_pkg::box_t held_box  [STORE];
	int             held_count;
	logic [31:0]    key_counter;

	assignment_t pending_assignments[$];
	int  mismatches;
	int  results_seen;
	int  frames_sent;
	int  full_hits;
	int  new_tracks;
	bit  calm;
	int  stuck_cycles = 0;
	int  out_hold;

	function automatic int wait_draw();
		return calm ? 0 : $urandom_range(0, 18);
	endfunction

	// Edges are in doubled units so that half sizes stay exact.
	function automatic void box_overlap(input gita_pkg::box_t a, input gita_pkg::box_t b,
			output logic [63:0] num, output logic [63:0] den);
		longint ax0, ax1, ay0, ay1, bx0, bx1, by0, by1, ix, iy, inter, uni;
		ax0 = 2 * longint'(a.cx) - longint'(a.w);
		ax1 = 2 * longint'(a.cx) + longint'(a.w);
		ay0 = 2 * longint'(a.cy) - longint'(a.h);
		ay1 = 2 * longint'(a.cy) + longint'(a.h);
		bx0 = 2 * longint'(b.cx) - longint'(b.w);
		bx1 = 2 * longint'(b.cx) + longint'(b.w);
		by0 = 2 * longint'(b.cy) - longint'(b.h);
		by1 = 2 * longint'(b.cy) + longint'(b.h);
		ix = ((ax1 < bx1) ? ax1 : bx1) - ((ax0 > bx0) ? ax0 : bx0);
		iy = ((ay1 < by1) ? ay1 : by1) - ((ay0 > by0) ? ay0 : by0);
		if (ix < 0) ix = 0;
		if (iy < 0) iy = 0;
		inter = ix * iy;
		uni = (ax1 - ax0) * (ay1 - ay0) + (bx1 - bx0) * (by1 - by0) - inter;
		if (uni == 0) begin
			num = 0;
			den = 1;
		end else begin
			num = inter;
			den = uni;
		end
	endfunction

	function automatic logic [63:0] centre_gap_sq(input gita_pkg::box_t a,
			input gita_pkg::box_t b);
		longint dx, dy;
		dx = longint'(a.cx) - longint'(b.cx);
		dy = longint'(a.cy) - longint'(b.cy);
		return dx * dx + dy * dy;
	endfunction

	// Runs the tracker on one accepted request and appends the assignments it causes.
	function automatic void associate(input request_t rq, ref assignment_t made[$]);
		bit          box_done [STORE];
		bit          slot_done [SLOTS];
		int          box_slot [STORE];
		int          n, r, t, br, bt;
		bit          found;
		logic [63:0] bn, bd, num, den, best, d;
		logic [127:0] lhs, rhs;
		assignment_t a;
		if (rq.carries_box && held_count < STORE) begin
			held_box[held_count] = rq.box;
			held_count++;
		end
		if (!rq.closes_frame) return;
		n = held_count;
		held_count = 0;
		for (t = 0; t < SLOTS; t++) begin
			if (slot_live[t] && rq.stamp > slot_seen[t] && rq.stamp - slot_seen[t] > stale_limit)
				slot_live[t] = 0;
			slot_done[t] = 0;
		end
		for (r = 0; r < STORE; r++) begin
			box_done[r] = 0;
			box_slot[r] = 0;
		end
		// Overlap pass: the best ratio wins, earlier pairs win ties.
		do begin
			bn = overlap_floor;
			bd = 65536;
			found = 0;
			br = 0;
			bt = 0;
			for (r = 0; r < n; r++) begin
				if (box_done[r]) continue;
				for (t = 0; t < SLOTS; t++) begin
					if (!slot_live[t] || slot_done[t]) continue;
					box_overlap(held_box[r], slot_box[t], num, den);
					lhs = num;
					lhs = lhs * bd;
					rhs = bn;
					rhs = rhs * den;
					if (found ? lhs > rhs : lhs >= rhs) begin
						bn = num;
						bd = den;
						br = r;
						bt = t;
						found = 1;
					end
				end
			end
			if (found) begin
				box_done[br] = 1;
				slot_done[bt] = 1;
				box_slot[br] = bt;
			end
		end while (found);
		// Distance pass over whatever the overlap pass left unmatched.
		do begin
			best = centre_radius;
			best = best * best;
			found = 0;
			br = 0;
			bt = 0;
			for (r = 0; r < n; r++) begin
				if (box_done[r]) continue;
				for (t = 0; t < SLOTS; t++) begin
					if (!slot_live[t] || slot_done[t]) continue;
					d = centre_gap_sq(held_box[r], slot_box[t]);
					if (found ? d < best : d <= best) begin
						best = d;
						br = r;
						bt = t;
						found = 1;
					end
				end
			end
			if (found) begin
				box_done[br] = 1;
				slot_done[bt] = 1;
				box_slot[br] = bt;
			end
		end while (found);
		for (r = 0; r < n; r++) begin
			a = '{key: 0, fresh: 0, full: 0, last: (r + 1 == n)};
			if (box_done[r]) begin
				t = box_slot[r];
				slot_box[t] = held_box[r];
				slot_seen[t] = rq.stamp;
				a.key = slot_key[t];
			end else begin
				for (t = 0; t < SLOTS && slot_live[t]; t++) ;
				if (t == SLOTS) begin
					a.full = 1;
				end else begin
					slot_live[t] = 1;
					slot_key[t] = key_counter;
					slot_box[t] = held_box[r];
					slot_seen[t] = rq.stamp;
					a.key = key_counter;
					a.fresh = 1;
					key_counter++;
					if (key_counter == 0)
						key_counter = 1;
				end
			end
			made = {made, a};
		end
	endfunction

	// Drives one request after a random gap and returns once it has been accepted.
	task automatic send_request(input request_t rq);
		int          gap;
		assignment_t made[$];
		assignment_t typed_one;
		gap = wait_draw();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		centre_x   <= rq.box.cx;
		centre_y   <= rq.box.cy;
		box_width  <= rq.box.w;
		box_height <= rq.box.h;
		frame_time <= rq.stamp;
		has_box    <= rq.carries_box;
		frame_end  <= rq.closes_frame;
		do @(posedge clk); while (in_stall);
		associate(rq, made);
		if (rq.closes_frame)
			frames_sent++;
		if (rq.typed) begin
			typed_one = '{key: rq.key, fresh: rq.fresh, full: rq.full, last: rq.last};
			pending_assignments = {pending_assignments, typed_one};
		end else begin
			pending_assignments = {pending_assignments, made};
		end
	endtask

	// Registers are only touched once every assignment is out and the block has settled.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_assignments.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Leaves cfg_valid high so that back-to-back writes need one assignment per step.
	task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (index)
			gita_pkg::REG_MIN_OVERLAP: begin
				overlap_floor = value[16:0];
			end
			gita_pkg::REG_MAX_DIST: begin
				centre_radius = value[16:0];
			end
			gita_pkg::REG_TIMEOUT: begin
				stale_limit = value;
			end
			default: begin
			end
		endcase
	endtask

	task automatic configure(input logic [31:0] ov, input logic [31:0] rad,
			input logic [31:0] tmo, input bit poke_spare);
		drain();
		write_reg(gita_pkg::REG_MIN_OVERLAP, ov);
		write_reg(gita_pkg::REG_MAX_DIST, rad);
		write_reg(gita_pkg::REG_TIMEOUT, tmo);
		if (poke_spare)
			write_reg(REG_SPARE, $urandom);
		cfg_valid <= 1'b0;
	endtask

	function automatic request_t plain(input gita_pkg::box_t b, input logic [47:0] stamp,
			input bit hb, input bit fe);
		return '{box: b, stamp: stamp, carries_box: hb, closes_frame: fe,
			typed: 0, key: 0, fresh: 0, full: 0, last: 0};
	endfunction

	function automatic request_t typed_row(input gita_pkg::box_t b, input logic [47:0] stamp,
			input logic [31:0] key, input bit fresh);
		request_t rq;
		rq = plain(b, stamp, 1, 1);
		rq.typed = 1;
		rq.key = key;
		rq.fresh = fresh;
		rq.last = 1;
		return rq;
	endfunction

	// Checks every accepted assignment and draws the stall for the next one.
	always @(posedge clk) begin
		assignment_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_assignments.size() == 0) begin
				$display("%0t: unexpected assignment key %0d new %0b full %0b last %0b",
					$time, assigned_key, is_new, table_full, last_result);
				mismatches++;
			end else begin
				want = pending_assignments.pop_front();
				if (want.full)
					full_hits++;
				if (want.fresh)
					new_tracks++;
				if (assigned_key !== want.key) begin
					$display("%0t: assigned_key expected %0d actual %0d", $time, want.key,
						assigned_key);
					mismatches++;
				end
				if (is_new !== want.fresh) begin
					$display("%0t: is_new expected %0b actual %0b", $time, want.fresh, is_new);
					mismatches++;
				end
				if (table_full !== want.full) begin
					$display("%0t: table_full expected %0b actual %0b", $time, want.full,
						table_full);
					mismatches++;
				end
				if (last_result !== want.last) begin
					$display("%0t: last_result expected %0b actual %0b", $time, want.last,
						last_result);
					mismatches++;
				end
			end
			out_hold = wait_draw();
			out_stall <= (out_hold != 0);
		end else if (out_hold > 0) begin
			out_hold--;
			out_stall <= (out_hold != 0);
		end
	end

	// Watchdog: a long run of cycles with no accepted request on any channel ends the run.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("greedy_iou_track_associator test failed");
			$finish;
		end
	end

	initial begin
		request_t       directed[$];
		gita_pkg::box_t scene[10];
		gita_pkg::box_t b;
		logic [47:0]    clock_us;
		int             sent, phase, boxes, k;

		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		centre_x = '0;
		centre_y = '0;
		box_width = '0;
		box_height = '0;
		frame_time = '0;
		has_box = 1'b0;
		frame_end = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatches = 0;
		results_seen = 0;
		frames_sent = 0;
		full_hits = 0;
		new_tracks = 0;
		calm = 0;
		out_hold = 0;

		overlap_floor = gita_pkg::MIN_OVERLAP_RST;
		centre_radius = gita_pkg::MAX_DIST_RST;
		stale_limit = gita_pkg::TIMEOUT_RST;
		foreach (slot_live[i]) begin
			slot_live[i] = 0;
			slot_key[i] = 0;
			slot_box[i] = '0;
			slot_seen[i] = 0;
		end
		held_count = 0;
		key_counter = 1;

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		// Directed part. The first three rows read straight off the reset state: a zero
		// box opens key 1, a full-range box overlaps nothing and opens key 2, and the same
		// full-range box again has an IoU of one and keeps key 2.
		directed = {directed, typed_row('0, 48'd0, 32'd1, 1)};
		directed = {directed, typed_row('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 48'd0,
			32'd2, 1)};
		directed = {directed, typed_row('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 48'd5,
			32'd2, 0)};
		// An empty frame still runs expiry but yields nothing; a boxless mid-frame
		// request is simply stored as nothing.
		directed = {directed, plain('0, 48'd10, 0, 1)};
		directed = {directed, plain('1, 48'd11, 0, 0)};
		// Nine far-apart boxes: six new tracks fill the table, two find it full and
		// the ninth overflows the box store and gets no result.
		for (k = 0; k < 9; k++)
			directed = {directed, plain('{16'(1000 + 7000 * k), 16'd30000, 16'd2000,
				16'd2000}, 48'd20, 1, (k == 8))};
		// Past the timeout every track is dropped before matching.
		directed = {directed, plain('{16'd1000, 16'd30000, 16'd2000, 16'd2000},
			48'd1000021, 1, 1)};
		directed = {directed, plain('{16'h8000, 16'h7FFF, 16'hFFFF, 16'd1},
			48'hFFFF_FFFF_FFFF, 1, 1)};
		foreach (directed[i])
			send_request(directed[i]);

		// Random part: five register settings, with low and high extremes among them.
		// Mostly a handful of people drifting between frames, so the matcher sees real
		// overlap and distance decisions; now and then wild boxes and odd frames.
		foreach (scene[i])
			scene[i] = '{16'($urandom), 16'($urandom), 16'($urandom_range(200, 6000)),
				16'($urandom_range(200, 6000))};
		clock_us = 48'd2000000;
		sent = 0;
		for (phase = 0; phase < 5; phase++) begin
			case (phase)
				0: configure(gita_pkg::MIN_OVERLAP_RST, gita_pkg::MAX_DIST_RST,
					gita_pkg::TIMEOUT_RST, 0);
				1: configure(32'h0, 32'h0, 32'h0, 1);
				2: configure(32'h0001_0000, 32'h0001_FFFF, 32'hFFFF_FFFF, 0);
				3: configure($urandom, $urandom, $urandom_range(0, 3000000), 0);
				default: configure($urandom_range(8000, 60000) | 32'hFFFE_0000,
					$urandom_range(100, 20000), $urandom_range(100000, 1500000), 1);
			endcase
			calm = (phase == 2);
			while (sent < (phase + 1) * RANDOM_ITEMS / 5) begin
				k = $urandom_range(0, 39);
				if (k == 0)
					clock_us = 48'($urandom) << 16 | 48'($urandom_range(0, 65535));
				else if (k < 3)
					clock_us += 48'($urandom_range(1000000, 4000000));
				else
					clock_us += 48'($urandom_range(10000, 400000));
				k = $urandom_range(0, 19);
				boxes = (k == 0) ? 0 : (k < 3) ? $urandom_range(7, 10) : $urandom_range(1, 5);
				for (int i = 0; i < boxes; i++) begin
					k = $urandom_range(0, 15);
					if (k == 0) begin
						b = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
					end else if (k < 3) begin
						b = '{16'($urandom), 16'($urandom), 16'($urandom_range(100, 8000)),
							16'($urandom_range(100, 8000))};
						scene[i] = b;
					end else begin
						b = scene[i];
						b.cx += 16'($urandom_range(0, 600)) - 16'd300;
						b.cy += 16'($urandom_range(0, 600)) - 16'd300;
						b.w += 16'($urandom_range(0, 200)) - 16'd100;
						b.h += 16'($urandom_range(0, 200)) - 16'd100;
						scene[i] = b;
					end
					if ($urandom_range(0, 9) == 0)
						send_request(plain('{16'($urandom), 16'($urandom), 16'($urandom),
							16'($urandom)}, 48'($urandom), 0, 0));
					send_request(plain(b, clock_us, 1,
						(i == boxes - 1) && $urandom_range(0, 7) != 0));
					sent++;
				end
				// Close with a boxless request when the last box did not close the frame.
				if (boxes == 0 || !frame_end) begin
					send_request(plain('{16'($urandom), 16'($urandom), 16'($urandom),
						16'($urandom)}, clock_us, 0, 1));
					sent++;
				end
			end
		end

		drain();
		$display("Covered %0d frames over five register settings: %0d assignments checked,",
			frames_sent, results_seen);
		$display("%0d new tracks opened and %0d full-table results.", new_tracks, full_hits);
		if (mismatches == 0) begin
			$display("greedy_iou_track_associator test passed");
		end else begin
			$display("greedy_iou_track_associator test failed");
		end
		$finish;
	end

endmodule
